// ----- design/pngu_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and register indexes for the PNG scanline unfilter.
package pngu_pkg;

    localparam int MAX_ROW_BYTES   = 16384;
    localparam int MAX_PIXEL_BYTES = 8;

    localparam int COL_W  = $clog2(MAX_ROW_BYTES);
    localparam int SLOT_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

    localparam int PPR_W     = 12;
    localparam int BPP_W     = 4;
    localparam int RPI_W     = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_PIXELS_PER_ROW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_PER_IMAGE  = 2'd2;

    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic              is_err;
        logic [7:0]        data;
        logic [2:0]        filter;
        logic [COL_W-1:0]  col;
        logic [SLOT_W-1:0] slot;
        logic              has_left;
        logic              first_row;
        logic              end_row;
        logic              end_image;
    } work_t;

endpackage

// ----- design/png_scanline_unfilter_top.sv -----
`timescale 1ns / 1ps
// PNG scanline unfilter: reconstructs inflated scanline bytes with None/Sub/Up/Average/Paeth.
//
// Input channel (in_valid/in_ready): one byte of the inflated stream per transaction.
// Each row opens with a filter-type byte that gives no result; image_start marks the
// first filter-type byte of an image. Output channel (out_valid/out_ready): one
// reconstructed byte per data transaction, with row and image end flags, or a single
// bad_filter result for a filter type above 4, after which bytes are dropped until
// the next image_start. Configuration is a plain write port (cfg_we, cfg_index,
// cfg_data) for width, bytes per pixel and rows per image; write only while idle.
// Throughput is one byte per cycle while the receiver keeps out_ready high. An input
// transaction goes into the work queue, then into the line-buffer read stage, then
// through the predictor into the output register. The line buffer read for a byte
// is bypassed when the byte above was written in the same cycle.
// A four-entry queue decouples the parser from the back end; in_ready drops only
// when that queue is full, so a stalled receiver back-pressures the input once
// the queue has filled. Reset empties the queue and output register, restores
// the register defaults and waits for a filter-type byte; the line buffer needs
// no clearing, the first row of an image never reads it.
module png_scanline_unfilter_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pngu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pngu_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     in_byte,
    input  logic                           image_start,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     pixel_byte,
    output logic                           last_of_row,
    output logic                           last_of_image,
    output logic                           bad_filter
);
    import pngu_pkg::*;

    logic  push;
    work_t push_entry;
    logic  pop;
    logic  head_valid;
    work_t head_entry;
    logic  q_full;

    pngu_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .image_start (image_start),
        .q_full      (q_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    pngu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .full       (q_full)
    );

    pngu_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_entry    (head_entry),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_byte    (pixel_byte),
        .last_of_row   (last_of_row),
        .last_of_image (last_of_image),
        .bad_filter    (bad_filter)
    );

endmodule

// ----- design/pngu_front.sv -----
`timescale 1ns / 1ps
// Front end: configuration registers, stream parsing, column and row tracking.
module pngu_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pngu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pngu_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     in_byte,
    input  logic                           image_start,
    input  logic                           q_full,
    output logic                           push,
    output pngu_pkg::work_t                push_entry
);
    import pngu_pkg::*;

    localparam int PROD_W = PPR_W + BPP_W;
    localparam int RB_W   = COL_W + 1;
    localparam int CMP_W  = (RB_W > PROD_W) ? RB_W : PROD_W;
    localparam int ROW_W  = RPI_W + 1;

    logic [PPR_W-1:0]  ppr_reg;
    logic [BPP_W-1:0]  bpp_reg;
    logic [RPI_W-1:0]  rpi_reg;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [RPI_W-1:0]  row_reg, row_next;
    logic [2:0]        filter_reg, filter_next;
    logic              await_reg, await_next;
    logic              first_reg, first_next;
    logic              err_reg, err_next;
    logic [SLOT_W-1:0] rem_reg  [MAX_PIXEL_BYTES];
    logic [SLOT_W-1:0] rem_next [MAX_PIXEL_BYTES];

    logic              accept;
    logic [PPR_W-1:0]  ppr_eff;
    logic [BPP_W-1:0]  bpp_eff;
    logic [BPP_W-1:0]  bpp_m1;
    logic [RPI_W-1:0]  rpi_eff;
    logic [PROD_W-1:0] prod;
    logic [CMP_W-1:0]  row_bytes;
    logic [CMP_W-1:0]  col_inc;
    logic [ROW_W-1:0]  row_inc;
    logic              end_row;
    logic              end_image;
    logic [SLOT_W-1:0] slot;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        ppr_eff = (ppr_reg == '0) ? PPR_W'(1) : ppr_reg;
        if (bpp_reg == '0)
            bpp_eff = BPP_W'(1);
        else if (bpp_reg > BPP_W'(MAX_PIXEL_BYTES))
            bpp_eff = BPP_W'(MAX_PIXEL_BYTES);
        else
            bpp_eff = bpp_reg;
        rpi_eff = (rpi_reg == '0) ? RPI_W'(1) : rpi_reg;
        bpp_m1  = bpp_eff - BPP_W'(1);
        prod    = PROD_W'(ppr_eff) * PROD_W'(bpp_eff);
        if (CMP_W'(prod) > CMP_W'(MAX_ROW_BYTES))
            row_bytes = CMP_W'(MAX_ROW_BYTES);
        else
            row_bytes = CMP_W'(prod);
    end

    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        filter_next = filter_reg;
        await_next  = await_reg;
        first_next  = first_reg;
        err_next    = err_reg;
        rem_next    = rem_reg;
        push        = 1'b0;
        push_entry  = '0;
        col_inc     = '0;
        row_inc     = '0;
        end_row     = 1'b0;
        end_image   = 1'b0;
        slot        = '0;

        if (accept)
        begin
            if (image_start)
            begin
                err_next   = 1'b0;
                row_next   = '0;
                col_next   = '0;
                first_next = 1'b1;
                await_next = 1'b1;
            end
            if (!err_next)
            begin
                if (await_next)
                begin
                    if (in_byte > 8'(FILT_PAETH))
                    begin
                        err_next          = 1'b1;
                        push              = 1'b1;
                        push_entry.is_err = 1'b1;
                    end
                    else
                    begin
                        filter_next = in_byte[2:0];
                        await_next  = 1'b0;
                        col_next    = '0;
                        for (int i = 0; i < MAX_PIXEL_BYTES; i++)
                        begin
                            rem_next[i] = '0;
                        end
                    end
                end
                else
                begin
                    slot      = rem_next[bpp_m1[SLOT_W-1:0]];
                    col_inc   = CMP_W'(col_next) + CMP_W'(1);
                    row_inc   = ROW_W'(row_next) + ROW_W'(1);
                    end_row   = col_inc >= row_bytes;
                    end_image = end_row && (row_inc >= ROW_W'(rpi_eff));

                    push                 = 1'b1;
                    push_entry.data      = in_byte;
                    push_entry.filter    = filter_next;
                    push_entry.col       = col_next;
                    push_entry.slot      = slot;
                    push_entry.has_left  = CMP_W'(col_next) >= CMP_W'(bpp_eff);
                    push_entry.first_row = first_next;
                    push_entry.end_row   = end_row;
                    push_entry.end_image = end_image;

                    col_next = col_inc[COL_W-1:0];
                    for (int i = 0; i < MAX_PIXEL_BYTES; i++)
                    begin
                        if (rem_next[i] == SLOT_W'(i))
                            rem_next[i] = '0;
                        else
                            rem_next[i] = rem_next[i] + SLOT_W'(1);
                    end

                    if (end_row)
                    begin
                        col_next   = '0;
                        await_next = 1'b1;
                        first_next = 1'b0;
                        row_next   = row_inc[RPI_W-1:0];
                        for (int i = 0; i < MAX_PIXEL_BYTES; i++)
                        begin
                            rem_next[i] = '0;
                        end
                        if (end_image)
                        begin
                            row_next   = '0;
                            first_next = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppr_reg    <= PPR_W'(1);
            bpp_reg    <= BPP_W'(4);
            rpi_reg    <= RPI_W'(1);
            col_reg    <= '0;
            row_reg    <= '0;
            filter_reg <= FILT_NONE;
            await_reg  <= 1'b1;
            first_reg  <= 1'b1;
            err_reg    <= 1'b0;
            for (int i = 0; i < MAX_PIXEL_BYTES; i++)
            begin
                rem_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PIXELS_PER_ROW:  ppr_reg <= cfg_data[PPR_W-1:0];
                    REG_BYTES_PER_PIXEL: bpp_reg <= cfg_data[BPP_W-1:0];
                    REG_ROWS_PER_IMAGE:  rpi_reg <= cfg_data[RPI_W-1:0];
                    default:             ;
                endcase
            end
            col_reg    <= col_next;
            row_reg    <= row_next;
            filter_reg <= filter_next;
            await_reg  <= await_next;
            first_reg  <= first_next;
            err_reg    <= err_next;
            rem_reg    <= rem_next;
        end
    end

endmodule

// ----- design/pngu_queue.sv -----
`timescale 1ns / 1ps
// Short work queue between the front end and the reconstruction back end.
module pngu_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pngu_pkg::work_t push_entry,
    input  logic            pop,
    output logic            head_valid,
    output pngu_pkg::work_t head_entry,
    output logic            full
);
    import pngu_pkg::*;

    work_t             slots_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head_entry = slots_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slots_mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + (QPTR_W+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (QPTR_W+1)'(1);
        end
    end

endmodule

// ----- design/pngu_back.sv -----
`timescale 1ns / 1ps
// Back end: line buffer, neighbor history, predictor and output register.
module pngu_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  pngu_pkg::work_t head_entry,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      pixel_byte,
    output logic            last_of_row,
    output logic            last_of_image,
    output logic            bad_filter
);
    import pngu_pkg::*;

    function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        logic signed [9:0] db;
        logic signed [9:0] da;
        logic signed [9:0] dp;
        logic [9:0]        pa;
        logic [9:0]        pb;
        logic [9:0]        pc;
        db = $signed({2'b00, b}) - $signed({2'b00, c});
        da = $signed({2'b00, a}) - $signed({2'b00, c});
        dp = da + db;
        pa = db[9] ? 10'(-db) : 10'(db);
        pb = da[9] ? 10'(-da) : 10'(da);
        pc = dp[9] ? 10'(-dp) : 10'(dp);
        if (pa <= pb && pa <= pc)
            return a;
        else if (pb <= pc)
            return b;
        else
            return c;
    endfunction

    logic [7:0] line_mem [MAX_ROW_BYTES];
    logic [7:0] left_hist [MAX_PIXEL_BYTES];
    logic [7:0] ul_hist   [MAX_PIXEL_BYTES];

    logic       exec_valid_reg;
    work_t      exec_reg;
    logic [7:0] rd_data_reg;
    logic       byp_reg;
    logic [7:0] byp_data_reg;

    logic       out_valid_reg;
    logic [7:0] pixel_reg;
    logic       last_row_reg;
    logic       last_img_reg;
    logic       bad_reg;

    logic       fire;
    logic       wr_en;
    logic [7:0] left;
    logic [7:0] up;
    logic [7:0] up_left;
    logic [8:0] avg_sum;
    logic [7:0] pred;
    logic [7:0] value;

    assign fire  = exec_valid_reg && (!out_valid_reg || out_ready);
    assign pop   = head_valid && (!exec_valid_reg || fire);
    assign wr_en = fire && !exec_reg.is_err;

    always_comb
    begin
        left    = exec_reg.has_left ? left_hist[exec_reg.slot] : 8'd0;
        if (exec_reg.first_row)
            up = 8'd0;
        else
            up = byp_reg ? byp_data_reg : rd_data_reg;
        up_left = (exec_reg.has_left && !exec_reg.first_row) ? ul_hist[exec_reg.slot] : 8'd0;
        avg_sum = {1'b0, left} + {1'b0, up};
        case (exec_reg.filter)
            FILT_SUB:   pred = left;
            FILT_UP:    pred = up;
            FILT_AVG:   pred = avg_sum[8:1];
            FILT_PAETH: pred = paeth_pred(left, up, up_left);
            default:    pred = 8'd0;
        endcase
        value = exec_reg.data + pred;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            line_mem[exec_reg.col] <= value;
        if (pop)
        begin
            exec_reg     <= head_entry;
            rd_data_reg  <= line_mem[head_entry.col];
            byp_data_reg <= value;
        end
        if (fire)
        begin
            pixel_reg    <= exec_reg.is_err ? 8'd0 : value;
            last_row_reg <= !exec_reg.is_err && exec_reg.end_row;
            last_img_reg <= !exec_reg.is_err && exec_reg.end_image;
            bad_reg      <= exec_reg.is_err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exec_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            byp_reg        <= 1'b0;
            for (int i = 0; i < MAX_PIXEL_BYTES; i++)
            begin
                left_hist[i] <= 8'd0;
                ul_hist[i]   <= 8'd0;
            end
        end
        else
        begin
            if (pop)
            begin
                exec_valid_reg <= 1'b1;
                byp_reg        <= wr_en && (exec_reg.col == head_entry.col);
            end
            else if (fire)
                exec_valid_reg <= 1'b0;

            if (fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (wr_en)
            begin
                left_hist[exec_reg.slot] <= value;
                ul_hist[exec_reg.slot]   <= up;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign pixel_byte    = pixel_reg;
    assign last_of_row   = last_row_reg;
    assign last_of_image = last_img_reg;
    assign bad_filter    = bad_reg;

endmodule

// ----- design/pngu_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the PNG scanline unfilter, bound to the top level.
module pngu_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] pixel_byte,
    input logic       last_of_row,
    input logic       last_of_image,
    input logic       bad_filter
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output transaction dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(pixel_byte) && $stable(last_of_row)
                                    && $stable(last_of_image) && $stable(bad_filter))
        else $error("output payload changed while stalled");

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_filter |-> pixel_byte == 8'd0 && !last_of_row && !last_of_image)
        else $error("error result carries data or end flags");

    a_image_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_image |-> last_of_row)
        else $error("image end without row end");

    a_no_output_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !$past(in_valid && in_ready) && !$past(in_valid && in_ready, 2)
        && !$past(out_valid) |=> !out_valid || $past(in_valid && in_ready, 2))
        else $error("result appeared without a recent input transaction");

endmodule

bind png_scanline_unfilter_top pngu_checker u_pngu_checker (.*);
